// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the scanner RTL.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define JTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/jts_pkg.sv -----
package jts_pkg;

  // Token kinds carried on the result channel.
  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COMMA    = 4'd4,
    TK_COLON    = 4'd5,
    TK_NULL     = 4'd6,
    TK_TRUE     = 4'd7,
    TK_FALSE    = 4'd8,
    TK_INT      = 4'd9,
    TK_REAL     = 4'd10,
    TK_SCHAR    = 4'd11,
    TK_SEND     = 4'd12,
    TK_EOF      = 4'd13,
    TK_ERR      = 4'd14
  } tok_t;

  // Error codes for error tokens.
  typedef enum logic [1:0] {
    ERR_UNKNOWN = 2'd0,
    ERR_LITERAL = 2'd1,
    ERR_END     = 2'd2
  } err_t;

  // Literal kinds.
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LOWER_N  = 8'h6E;
  localparam logic [7:0] CH_LOWER_T  = 8'h74;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;

  // Result channel widths.
  localparam int OUT_TDATA_W = 48;
  localparam int NUM_OUT_W   = 31;

  // One result item.
  typedef struct packed {
    tok_t                 token_kind;
    logic [NUM_OUT_W-1:0] number_value;
    logic [3:0]           fraction_digits;
    logic                 number_overflow;
    logic [7:0]           string_char;
    err_t                 error_code;
    logic                 is_last;
  } res_t;

  // Number of letters in each literal.
  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    unique case (kind)
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  // Expected letter of a literal at a given position.
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kind)
      LIT_TRUE: begin
        unique case (pos)
          3'd0:    ch = 8'h74;
          3'd1:    ch = 8'h72;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0:    ch = 8'h66;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h73;
          3'd4:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0:    ch = 8'h6E;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/json_token_scanner_unit.sv -----
// Streaming JSON tokenizer.
// Input channel: one transfer per byte of text. in_tdata holds the byte and
// in_tuser marks the end of the text; the byte is ignored on an end transfer.
// Result channel: one transfer per token. out_tuser holds the token kind,
// out_tdata the number, fraction count, overflow flag, string byte and error
// code, and out_tlast marks the last token caused by one input transfer.
// Each input transfer yields zero, one or two tokens. Two tokens arise when a
// number is closed by a character that gives a token of its own or by the end
// marker, and when the text ends inside a literal or a string.
// The tokens of a byte are written into the queue when the byte is taken.
// Throughput: one byte per cycle while in_tready is high. The tokens wait in a
// three-entry queue, and in_tready is high while the queue holds at most one
// token, so a byte that gives two tokens holds in_tready low for one cycle while
// the receiver keeps up. When the receiver stalls, the queue fills and in_tready
// drops; no token is lost. Reset empties the queue and returns the scanner
// to the state between tokens with a cleared number.
`include "assert_macros.svh"

module json_token_scanner_unit #(
  parameter int NUMBER_BITS = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] char_in
  input  logic                               in_tuser,   // [0] at_end
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [30:0] number_value, [34:31] fraction_digits, [35] number_overflow,
  // [43:36] string_char, [45:44] error_code, [47:46] zero
  output logic [jts_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [3:0]                         out_tuser,  // [3:0] token_kind
  output logic                               out_tlast   // is_last
);
  import jts_pkg::*;

  localparam int NumW = (NUMBER_BITS > NUM_OUT_W) ? NUMBER_BITS : NUM_OUT_W;
  localparam logic [NUMBER_BITS+3:0] MantLimit = {4'b0000, {NUMBER_BITS{1'b1}}};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LIT,
    MODE_INT,
    MODE_FRAC,
    MODE_STR
  } mode_t;

  // Scanner state.
  mode_t                  mode_r, mode_nxt;
  logic [1:0]             lit_kind_r, lit_kind_nxt;
  logic [2:0]             lit_pos_r, lit_pos_nxt;
  logic [NUMBER_BITS-1:0] mant_r, mant_nxt;
  logic [3:0]             frac_r, frac_nxt;
  logic                   sat_r, sat_nxt;

  // Result queue.
  res_t                   fifo_r [3];
  logic [1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [1:0]             count_r, count_nxt;

  // Results of the current byte.
  res_t                   res0, res1, start_res;
  logic [1:0]             n_res;
  logic                   again, start_valid;

  logic                   in_acc, out_acc;
  logic [7:0]             ch;
  logic                   at_end, is_digit;
  logic [3:0]             digit;
  logic [NUMBER_BITS+3:0] mant_ten;
  logic                   mant_over;
  logic [NumW-1:0]        mant_wide;
  logic [1:0]             kind_eff;
  logic [2:0]             len_eff, pos_eff, pos_inc;

  // Conditions checked by the assertions.
  logic                   scan_clear, lit_pos_ok;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign ch      = in_tdata;
  assign at_end  = in_tuser;
  assign is_digit = !at_end && (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit   = 4'(ch - CH_ZERO);

  // Multiply-accumulate for one decimal digit, with saturation check.
  assign mant_ten  = {mant_r, 3'b000} + {2'b00, mant_r, 1'b0} + (NUMBER_BITS+4)'(digit);
  assign mant_over = mant_ten > MantLimit;
  assign mant_wide = NumW'(mant_r);

  // Literal letter lookup; out-of-range state falls back to the first letter.
  assign kind_eff = (lit_kind_r == 2'd3) ? LIT_NULL : lit_kind_r;
  assign len_eff  = lit_len(kind_eff);
  assign pos_eff  = (lit_pos_r < len_eff) ? lit_pos_r : 3'd0;
  assign pos_inc  = pos_eff + 3'd1;

  // Token scan for one byte.
  always_comb begin
    mode_nxt     = mode_r;
    lit_kind_nxt = lit_kind_r;
    lit_pos_nxt  = lit_pos_r;
    mant_nxt     = mant_r;
    frac_nxt     = frac_r;
    sat_nxt      = sat_r;
    res0         = '0;
    res1         = '0;
    start_res    = '0;
    start_valid  = 1'b0;
    n_res        = 2'd0;
    again        = 1'b1;

    // Continue the token in progress.
    unique case (mode_r)
      MODE_INT, MODE_FRAC: begin
        if (is_digit) begin
          again = 1'b0;
          if (mode_r == MODE_FRAC && frac_r == 4'd15) begin
            sat_nxt = 1'b1;
          end else begin
            if (mant_over) begin
              mant_nxt = {NUMBER_BITS{1'b1}};
              sat_nxt  = 1'b1;
            end else begin
              mant_nxt = mant_ten[NUMBER_BITS-1:0];
            end
            if (mode_r == MODE_FRAC) begin
              frac_nxt = frac_r + 4'd1;
            end
          end
        end else if (!at_end && ch == CH_POINT && mode_r == MODE_INT) begin
          again    = 1'b0;
          mode_nxt = MODE_FRAC;
        end else begin
          res0.token_kind      = (mode_r == MODE_INT) ? TK_INT : TK_REAL;
          res0.number_value    = mant_wide[NUM_OUT_W-1:0];
          res0.fraction_digits = (mode_r == MODE_INT) ? 4'd0 : frac_r;
          res0.number_overflow = sat_r;
          n_res    = 2'd1;
          mant_nxt = '0;
          frac_nxt = 4'd0;
          sat_nxt  = 1'b0;
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STR: begin
        if (at_end) begin
          res0.token_kind = TK_ERR;
          res0.error_code = ERR_END;
          n_res    = 2'd1;
          mode_nxt = MODE_IDLE;
        end else begin
          again = 1'b0;
          n_res = 2'd1;
          if (ch == CH_QUOTE) begin
            res0.token_kind = TK_SEND;
            mode_nxt        = MODE_IDLE;
          end else begin
            res0.token_kind  = TK_SCHAR;
            res0.string_char = ch;
          end
        end
      end
      MODE_LIT: begin
        if (at_end) begin
          res0.token_kind = TK_ERR;
          res0.error_code = ERR_END;
          n_res    = 2'd1;
          mode_nxt = MODE_IDLE;
        end else begin
          again = 1'b0;
          if (ch != lit_char(kind_eff, pos_eff)) begin
            res0.token_kind = TK_ERR;
            res0.error_code = ERR_LITERAL;
            n_res       = 2'd1;
            mode_nxt    = MODE_IDLE;
            lit_pos_nxt = 3'd0;
          end else if (pos_inc >= len_eff) begin
            unique case (kind_eff)
              LIT_NULL: res0.token_kind = TK_NULL;
              LIT_TRUE: res0.token_kind = TK_TRUE;
              default:  res0.token_kind = TK_FALSE;
            endcase
            n_res       = 2'd1;
            mode_nxt    = MODE_IDLE;
            lit_pos_nxt = 3'd0;
          end else begin
            lit_pos_nxt = pos_inc;
          end
        end
      end
      default: begin
      end
    endcase

    // Start a new token with this byte, or close the text.
    if (again) begin
      if (at_end) begin
        start_res.token_kind = TK_EOF;
        start_valid  = 1'b1;
        mode_nxt     = MODE_IDLE;
        lit_kind_nxt = LIT_NULL;
        lit_pos_nxt  = 3'd0;
        mant_nxt     = '0;
        frac_nxt     = 4'd0;
        sat_nxt      = 1'b0;
      end else begin
        mode_nxt = MODE_IDLE;
        priority if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR) begin
          start_valid = 1'b0;
        end else if (ch == CH_LBRACE) begin
          start_res.token_kind = TK_LBRACE;
          start_valid = 1'b1;
        end else if (ch == CH_RBRACE) begin
          start_res.token_kind = TK_RBRACE;
          start_valid = 1'b1;
        end else if (ch == CH_LBRACKET) begin
          start_res.token_kind = TK_LBRACKET;
          start_valid = 1'b1;
        end else if (ch == CH_RBRACKET) begin
          start_res.token_kind = TK_RBRACKET;
          start_valid = 1'b1;
        end else if (ch == CH_COMMA) begin
          start_res.token_kind = TK_COMMA;
          start_valid = 1'b1;
        end else if (ch == CH_COLON) begin
          start_res.token_kind = TK_COLON;
          start_valid = 1'b1;
        end else if (ch == CH_LOWER_N || ch == CH_LOWER_T || ch == CH_LOWER_F) begin
          lit_kind_nxt = (ch == CH_LOWER_N) ? LIT_NULL :
                         (ch == CH_LOWER_T) ? LIT_TRUE : LIT_FALSE;
          lit_pos_nxt  = 3'd1;
          mode_nxt     = MODE_LIT;
        end else if (ch == CH_QUOTE) begin
          mode_nxt = MODE_STR;
        end else if (is_digit) begin
          mant_nxt = NUMBER_BITS'(digit);
          frac_nxt = 4'd0;
          sat_nxt  = 1'b0;
          mode_nxt = MODE_INT;
        end else begin
          start_res.token_kind = TK_ERR;
          start_res.error_code = ERR_UNKNOWN;
          start_valid = 1'b1;
        end
      end
    end

    // Append the start token and mark the last token of this byte.
    if (start_valid) begin
      if (n_res == 2'd0) begin
        res0 = start_res;
      end else begin
        res1 = start_res;
      end
      n_res = n_res + 2'd1;
    end
    if (n_res == 2'd2) begin
      res1.is_last = 1'b1;
    end else begin
      res0.is_last = 1'b1;
    end
  end

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (in_acc) begin
      if (n_res == 2'd1) begin
        wr_ptr_nxt = ptr_inc(wr_ptr_r);
      end else if (n_res == 2'd2) begin
        wr_ptr_nxt = ptr_inc(ptr_inc(wr_ptr_r));
      end
    end
    if (out_acc) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
    end
    count_nxt = count_r + (in_acc ? n_res : 2'd0) - {1'b0, out_acc};
  end

  // State and queue registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      lit_kind_r <= LIT_NULL;
      lit_pos_r  <= 3'd0;
      mant_r     <= '0;
      frac_r     <= 4'd0;
      sat_r      <= 1'b0;
      rd_ptr_r   <= 2'd0;
      wr_ptr_r   <= 2'd0;
      count_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      if (in_acc) begin
        mode_r     <= mode_nxt;
        lit_kind_r <= lit_kind_nxt;
        lit_pos_r  <= lit_pos_nxt;
        mant_r     <= mant_nxt;
        frac_r     <= frac_nxt;
        sat_r      <= sat_nxt;
        if (n_res != 2'd0) begin
          fifo_r[wr_ptr_r] <= res0;
        end
        if (n_res == 2'd2) begin
          fifo_r[ptr_inc(wr_ptr_r)] <= res1;
        end
      end
    end
  end

  // Output side of the queue.
  assign in_tready  = count_r < 2'd2;
  assign out_tvalid = count_r != 2'd0;
  assign out_tuser  = fifo_r[rd_ptr_r].token_kind;
  assign out_tlast  = fifo_r[rd_ptr_r].is_last;
  assign out_tdata  = {2'b00,
                       fifo_r[rd_ptr_r].error_code,
                       fifo_r[rd_ptr_r].string_char,
                       fifo_r[rd_ptr_r].number_overflow,
                       fifo_r[rd_ptr_r].fraction_digits,
                       fifo_r[rd_ptr_r].number_value};

  // Scanner idle with a clear number, and a literal position inside its literal.
  assign scan_clear = (mode_r == MODE_IDLE) && (mant_r == '0) && (frac_r == 4'd0);
  assign lit_pos_ok = (mode_r != MODE_LIT) ||
                      ((lit_pos_r != 3'd0) && (lit_pos_r < 3'd5) && (lit_kind_r != 2'd3));

  // The queue never holds more tokens than it has entries.
  `JTS_ASSERT_ALWAYS(a_queue_bound, count_r <= 2'd3, "result queue overfilled")
  // After the end marker the scanner is back between tokens with a clear number.
  `JTS_ASSERT_NEXT(a_eof_clears, in_acc && at_end, scan_clear, "scanner not cleared at end")
  // Inside a literal the letter position stays within the literal.
  `JTS_ASSERT_ALWAYS(a_lit_pos, lit_pos_ok, "literal position out of range")

endmodule
